>>> hdl/stks_pkg.sv
// shared types, constants and key functions for the streaming top-k selector
// no dependencies; used by every module under hdl
package stks_pkg;

    localparam int MAX_K_DEF        = 16;
    localparam int MAX_ELEMENTS_DEF = 262144;

    localparam int VALUE_W      = 32;
    localparam int POSITION_W   = 18;
    localparam int TOP_COUNT_W  = 5;
    localparam int S_TDATA_W    = 32;
    localparam int M_FIELDS_W   = POSITION_W + VALUE_W;
    localparam int M_TDATA_W    = ((M_FIELDS_W + 7) / 8) * 8;
    localparam int M_PAD_W      = M_TDATA_W - M_FIELDS_W;

    localparam logic [VALUE_W-1:0] SIGN_MASK = {1'b1, {(VALUE_W-1){1'b0}}};

    // one kept element: ordered key and its position in the run
    typedef struct packed {
        logic                  valid;
        logic [VALUE_W-1:0]    key;
        logic [POSITION_W-1:0] pos;
    } t_entry;

    // float bits to an unsigned-comparable key
    function automatic logic [VALUE_W-1:0] key_of(input logic [VALUE_W-1:0] bits);
        logic [VALUE_W-1:0] k;
        if (bits[VALUE_W-1]) begin
            k = ~bits;
        end else begin
            k = bits ^ SIGN_MASK;
        end
        return k;
    endfunction

    // inverse of key_of
    function automatic logic [VALUE_W-1:0] bits_of(input logic [VALUE_W-1:0] key);
        logic [VALUE_W-1:0] b;
        if (key[VALUE_W-1]) begin
            b = key ^ SIGN_MASK;
        end else begin
            b = ~key;
        end
        return b;
    endfunction

endpackage

>>> hdl/stks_ins_cell.sv
// one cell of the sorted insertion chain: holds one kept element
// depends on stks_pkg (t_entry)
module stks_ins_cell (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_ins,       // an element enters the chain this cycle
    input  logic           i_clear,     // end of run, empty the cell
    input  stks_pkg::t_entry i_new,
    input  stks_pkg::t_entry i_prev,    // contents of the better neighbor
    input  logic           i_prev_ins,  // new element lands at or above the neighbor
    output stks_pkg::t_entry o_entry,
    output logic           o_ins,
    output stks_pkg::t_entry o_next     // contents after this cycle's insert
);

    stks_pkg::t_entry r_entry;
    stks_pkg::t_entry n_entry;

    // strict compare keeps the earlier position ahead on ties
    assign o_ins = !r_entry.valid || (i_new.key > r_entry.key);

    always_comb begin
        n_entry = r_entry;
        if (i_ins) begin
            if (i_prev_ins) begin
                n_entry = i_prev;
            end else if (o_ins) begin
                n_entry = i_new;
            end
        end
    end

    assign o_next  = n_entry;
    assign o_entry = r_entry;

    always_ff @(posedge i_clk) begin
        r_entry.key <= n_entry.key;
        r_entry.pos <= n_entry.pos;
        if (!i_rst_n || i_clear) begin
            r_entry.valid <= 1'b0;
        end else begin
            r_entry.valid <= n_entry.valid;
        end
    end

endmodule

>>> hdl/stks_drain_cell.sv
// one cell of the result chain: loaded in parallel at end of run, shifts toward the output
// depends on stks_pkg (t_entry)
module stks_drain_cell (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_load,
    input  stks_pkg::t_entry i_load_entry,
    input  logic             i_shift,
    input  stks_pkg::t_entry i_succ,    // contents of the next cell down the chain
    output stks_pkg::t_entry o_entry
);

    stks_pkg::t_entry r_entry;
    stks_pkg::t_entry n_entry;

    always_comb begin
        n_entry = r_entry;
        if (i_load) begin
            n_entry = i_load_entry;
        end else if (i_shift) begin
            n_entry = i_succ;
        end
    end

    always_ff @(posedge i_clk) begin
        r_entry.key <= n_entry.key;
        r_entry.pos <= n_entry.pos;
        if (!i_rst_n) begin
            r_entry.valid <= 1'b0;
        end else begin
            r_entry.valid <= n_entry.valid;
        end
    end

    assign o_entry = r_entry;

endmodule

>>> hdl/streaming_top_k_selection.sv
// streaming top-k selector: top level with insertion chain, result chain and control
// depends on stks_pkg, stks_ins_cell, stks_drain_cell
//
//  channel  | dir | handshake            | contents
//  ---------+-----+----------------------+-------------------------------------------
//  s        | in  | i_s_tvalid/o_s_tready| tdata value[31:0], tlast last
//  m        | out | o_m_tvalid/i_m_tready| tdata position[17:0] score[49:18], tlast
//           |     |                      | final_res, tuser overflow
//  cfg      | in  | i_cfg_we             | i_cfg_wdata top_count[4:0]
//
// one element per cycle is taken while o_s_tready is high; each cell compares the new
// key with its own in the same cycle and the chain shifts by one below the insert point
// the first result is offered in the cycle after the element carrying tlast is taken;
// results then leave the result chain one per cycle while i_m_tready is high, best first
// an element carrying tlast waits while results of the previous run are pending, unless
// the final one of them leaves in the same cycle; other elements keep flowing
// reset (synchronous, active low) empties both chains, clears the element counter and
// sets top_count to 1; no clearing pass is needed
module streaming_top_k_selection #(
    parameter int MAX_K        = stks_pkg::MAX_K_DEF,
    parameter int MAX_ELEMENTS = stks_pkg::MAX_ELEMENTS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // input stream
    input  logic                              i_s_tvalid,
    output logic                              o_s_tready,
    input  logic [stks_pkg::S_TDATA_W-1:0]    i_s_tdata,  // value[31:0]
    input  logic                              i_s_tlast,  // last
    // result stream
    output logic                              o_m_tvalid,
    input  logic                              i_m_tready,
    output logic [stks_pkg::M_TDATA_W-1:0]    o_m_tdata,  // position[17:0], score[49:18]
    output logic                              o_m_tlast,  // final_res
    output logic [0:0]                        o_m_tuser,  // overflow
    // configuration
    input  logic                              i_cfg_we,
    input  logic [stks_pkg::TOP_COUNT_W-1:0]  i_cfg_wdata // top_count
);

    localparam int CNT_W = $clog2(MAX_ELEMENTS + 1);

    // configuration register
    logic [stks_pkg::TOP_COUNT_W-1:0] r_top_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_top_count <= stks_pkg::TOP_COUNT_W'(1);
        end else if (i_cfg_we) begin
            r_top_count <= i_cfg_wdata;
        end
    end

    // handshakes
    logic s_xfer;
    logic m_xfer;
    logic run_end;
    logic drain_free;

    stks_pkg::t_entry w_chain [MAX_K];
    stks_pkg::t_entry w_next  [MAX_K];
    logic             w_ins   [MAX_K];
    stks_pkg::t_entry w_drain [MAX_K+1];

    // result chain can take a new run when empty or its final result leaves now
    assign drain_free = !w_drain[0].valid || (i_m_tready && !w_drain[1].valid);
    assign o_s_tready = !i_s_tlast || drain_free;
    assign s_xfer     = i_s_tvalid && o_s_tready;
    assign m_xfer     = o_m_tvalid && i_m_tready;
    assign run_end    = s_xfer && i_s_tlast;

    // element counter and capacity flag
    logic [CNT_W-1:0] r_elem_cnt;
    logic             r_ovf;
    logic             at_cap;
    logic             ins_en;

    logic [CNT_W+stks_pkg::POSITION_W-1:0] pos_ext;

    assign at_cap  = (r_elem_cnt >= CNT_W'(MAX_ELEMENTS));
    assign ins_en  = s_xfer && !at_cap;
    // position is the counter taken to 18 bits
    assign pos_ext = {{stks_pkg::POSITION_W{1'b0}}, r_elem_cnt};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || run_end) begin
            r_elem_cnt <= '0;
            r_ovf      <= 1'b0;
        end else if (s_xfer) begin
            if (at_cap) begin
                r_ovf <= 1'b1;
            end else begin
                r_elem_cnt <= r_elem_cnt + CNT_W'(1);
            end
        end
    end

    stks_pkg::t_entry new_entry;

    always_comb begin
        new_entry.valid = 1'b1;
        new_entry.key   = stks_pkg::key_of(i_s_tdata[stks_pkg::VALUE_W-1:0]);
        new_entry.pos   = pos_ext[stks_pkg::POSITION_W-1:0];
    end

    // insertion chain, cell 0 holds the largest key
    genvar gi;
    generate
        for (gi = 0; gi < MAX_K; gi++) begin : g_ins
            stks_pkg::t_entry prev_entry;
            logic             prev_ins;
            if (gi == 0) begin : g_head
                assign prev_entry = '0;
                assign prev_ins   = 1'b0;
            end else begin : g_body
                assign prev_entry = w_chain[gi-1];
                assign prev_ins   = w_ins[gi-1];
            end

            stks_ins_cell u_cell (
                .i_clk      (i_clk),
                .i_rst_n    (i_rst_n),
                .i_ins      (ins_en),
                .i_clear    (run_end),
                .i_new      (new_entry),
                .i_prev     (prev_entry),
                .i_prev_ins (prev_ins),
                .o_entry    (w_chain[gi]),
                .o_ins      (w_ins[gi]),
                .o_next     (w_next[gi])
            );
        end
    endgenerate

    // result chain, loaded with the first top_count entries after the last insert
    assign w_drain[MAX_K] = '0;

    generate
        for (gi = 0; gi < MAX_K; gi++) begin : g_drain
            stks_pkg::t_entry load_entry;
            logic             keep;

            // top_count of zero acts as one; values above MAX_K select every cell
            assign keep = (gi == 0) || (gi < int'(r_top_count));

            always_comb begin
                load_entry       = w_next[gi];
                load_entry.valid = w_next[gi].valid && keep;
            end

            stks_drain_cell u_cell (
                .i_clk        (i_clk),
                .i_rst_n      (i_rst_n),
                .i_load       (run_end),
                .i_load_entry (load_entry),
                .i_shift      (m_xfer),
                .i_succ       (w_drain[gi+1]),
                .o_entry      (w_drain[gi])
            );
        end
    endgenerate

    // overflow flag travels with the whole run of results
    logic r_out_ovf;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_ovf <= 1'b0;
        end else if (run_end) begin
            r_out_ovf <= r_ovf || at_cap;
        end
    end

    assign o_m_tvalid = w_drain[0].valid;
    assign o_m_tdata  = {{stks_pkg::M_PAD_W{1'b0}},
                         stks_pkg::bits_of(w_drain[0].key),
                         w_drain[0].pos};
    assign o_m_tlast  = !w_drain[1].valid;
    assign o_m_tuser  = r_out_ovf;

    // chain stays a sorted prefix of valid cells
    generate
        for (gi = 1; gi < MAX_K; gi++) begin : g_chk
            a_sorted: assert property (@(posedge i_clk) disable iff (!i_rst_n)
                w_chain[gi].valid |->
                    (w_chain[gi-1].valid && (w_chain[gi-1].key >= w_chain[gi].key)))
                else $error("insertion chain out of order");
        end
    endgenerate

    // end of run empties the insertion chain
    a_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        run_end |=> !w_chain[0].valid)
        else $error("insertion chain not cleared at end of run");

    // every run produces at least one result
    a_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        run_end |=> o_m_tvalid)
        else $error("run ended without a result");

    // a run end is held off while results of the previous run remain
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_tlast && o_m_tvalid && !(i_m_tready && o_m_tlast)) |-> !o_s_tready)
        else $error("run end taken over pending results");

endmodule

>>> tb/tb_streaming_top_k_selection.sv
// self-checking testbench for streaming_top_k_selection: directed table, random runs,
// closing runs without idling; results checked against an in-bench model
// depends on stks_pkg and the streaming_top_k_selection top level
`timescale 1ns / 100ps

module tb_streaming_top_k_selection;

    localparam int VALUE_W     = stks_pkg::VALUE_W;
    localparam int POSITION_W  = stks_pkg::POSITION_W;
    localparam int TOP_COUNT_W = stks_pkg::TOP_COUNT_W;
    localparam int S_TDATA_W   = stks_pkg::S_TDATA_W;
    localparam int M_TDATA_W   = stks_pkg::M_TDATA_W;

    localparam int TOPK_MAX      = stks_pkg::MAX_K_DEF;
    localparam int ELEM_CAP      = stks_pkg::MAX_ELEMENTS_DEF;
    localparam int RANDOM_ITEMS  = 300;
    localparam int SETTLE_CYCLES = 24;        // quiet cycles before a register write
    localparam int HOLD_CYCLES   = 400;       // long receiver hold-off
    localparam int LIMIT_CYCLES  = 200_000;

    typedef enum logic {ROW_ITEM, ROW_CFG} t_row_kind;

    // one row of the directed table
    typedef struct {
        t_row_kind             kind;
        logic [VALUE_W-1:0]    value;     // element, or top_count for a cfg row
        logic                  last;
        bit                    typed;     // expectation typed in below
        logic [POSITION_W-1:0] t_pos;
        logic [VALUE_W-1:0]    t_score;
    } t_stim_row;

    // one ranked element as it leaves the block
    typedef struct packed {
        logic [POSITION_W-1:0] pos;
        logic [VALUE_W-1:0]    score;
        logic                  final_res;
        logic                  overflow;
    } t_ranked_elem;

    logic                    i_clk;
    logic                    i_rst_n   = 1'b0;
    logic                    s_tvalid  = 1'b0;
    logic [S_TDATA_W-1:0]    s_tdata   = '0;
    logic                    s_tlast   = 1'b0;
    logic                    m_tready  = 1'b0;
    logic                    cfg_we    = 1'b0;
    logic [TOP_COUNT_W-1:0]  cfg_wdata = '0;

    logic                    o_s_tready;
    logic                    o_m_tvalid;
    logic [M_TDATA_W-1:0]    o_m_tdata;
    logic                    o_m_tlast;
    logic [0:0]              o_m_tuser;

    // model state of the kept list, best first
    logic [VALUE_W-1:0]      kept_key   [TOPK_MAX];
    logic [VALUE_W-1:0]      kept_bits  [TOPK_MAX];
    logic [POSITION_W-1:0]   kept_pos   [TOPK_MAX];
    int                      kept_n     = 0;
    int                      run_count  = 0;
    bit                      run_over   = 1'b0;
    logic [TOP_COUNT_W-1:0]  k_setting  = 5'd1;

    t_ranked_elem            pending_ranks[$];
    t_stim_row               stim_rows[$];

    int                      mismatches   = 0;
    int                      cycle_count  = 0;
    bit                      idle_on      = 1'b1;
    bit                      quiet        = 1'b0;   // no idling in the closing part
    bit                      hold_done    = 1'b0;

    streaming_top_k_selection #(
        .MAX_K        (TOPK_MAX),
        .MAX_ELEMENTS (ELEM_CAP)
    ) DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (s_tdata),     // value[31:0]
        .i_s_tlast   (s_tlast),     // last
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (m_tready),
        .o_m_tdata   (o_m_tdata),   // position[17:0], score[49:18]
        .o_m_tlast   (o_m_tlast),   // final_res
        .o_m_tuser   (o_m_tuser),   // overflow
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata)    // top_count
    );

    // 2 ns clock
    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // run limit
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT_CYCLES) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // sign-magnitude float bits to a key that orders as unsigned
    function automatic logic [VALUE_W-1:0] float_order_key(input logic [VALUE_W-1:0] bits);
        return bits[VALUE_W-1] ? ~bits : {~bits[VALUE_W-1], bits[VALUE_W-2:0]};
    endfunction

    // takes one accepted element into the model; on last, queues the ranking
    // and starts a new run; with emit low the ranking is dropped (typed rows)
    function automatic void track_element(input logic [VALUE_W-1:0] value, input logic last,
                                          input bit emit);
        logic [VALUE_W-1:0] key;
        int                 slot;
        int                 top;
        int                 k_eff;
        int                 n_out;
        t_ranked_elem       r;
        key = float_order_key(value);
        if (run_count >= ELEM_CAP) begin
            // past the position capacity: ignored, only flagged
            run_over = 1'b1;
        end else begin
            slot = 0;
            // equal keys keep the earlier position ahead
            while (slot < kept_n && kept_key[slot] >= key) slot++;
            if (slot < TOPK_MAX) begin
                top = (kept_n < TOPK_MAX) ? kept_n : TOPK_MAX - 1;
                for (int i = top; i > slot; i--) begin
                    kept_key[i]  = kept_key[i-1];
                    kept_bits[i] = kept_bits[i-1];
                    kept_pos[i]  = kept_pos[i-1];
                end
                kept_key[slot]  = key;
                kept_bits[slot] = value;
                kept_pos[slot]  = run_count[POSITION_W-1:0];
                if (kept_n < TOPK_MAX) kept_n++;
            end
            run_count++;
        end
        if (last) begin
            // zero acts as one, anything above the list depth as the depth
            k_eff = (k_setting == 0) ? 1 : int'(k_setting);
            if (k_eff > TOPK_MAX) k_eff = TOPK_MAX;
            n_out = (kept_n < k_eff) ? kept_n : k_eff;
            for (int i = 0; i < n_out; i++) begin
                r.pos       = kept_pos[i];
                r.score     = kept_bits[i];
                r.final_res = (i == n_out - 1);
                r.overflow  = run_over;
                if (emit) pending_ranks.insert(pending_ranks.size(), r);
            end
            kept_n    = 0;
            run_count = 0;
            run_over  = 1'b0;
        end
    endfunction

    // offer one element and hold it until the transfer
    task automatic push_element(input logic [VALUE_W-1:0] value, input logic last,
                                input bit emit);
        if (idle_on && !quiet && $urandom_range(0, 3) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= value;
        s_tlast  <= last;
        @(posedge i_clk);
        while (!o_s_tready) @(posedge i_clk);
        track_element(value, last, emit);
    endtask

    task automatic release_input();
        s_tvalid <= 1'b0;
    endtask

    // all rankings out, then let any element still in the chain settle
    task automatic wait_idle();
        while (pending_ranks.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_top_count(input logic [TOP_COUNT_W-1:0] k);
        cfg_wdata <= k;
        cfg_we    <= 1'b1;
        @(posedge i_clk);
        cfg_we    <= 1'b0;
        k_setting  = k;
    endtask

    function automatic void add_row(input t_row_kind kind, input logic [VALUE_W-1:0] value,
                                    input logic last, input bit typed,
                                    input logic [POSITION_W-1:0] t_pos,
                                    input logic [VALUE_W-1:0] t_score);
        t_stim_row row;
        row.kind    = kind;
        row.value   = value;
        row.last    = last;
        row.typed   = typed;
        row.t_pos   = t_pos;
        row.t_score = t_score;
        stim_rows.insert(stim_rows.size(), row);
    endfunction

    // random element: plain bits mostly, with specials, ties and near values
    function automatic logic [VALUE_W-1:0] pick_value(input logic [VALUE_W-1:0] prev);
        logic [VALUE_W-1:0] v;
        case ($urandom_range(0, 9))
            0: begin
                case ($urandom_range(0, 8))
                    0: v = 32'h0000_0000;   // +0
                    1: v = 32'h8000_0000;   // -0
                    2: v = 32'h7F80_0000;   // +inf
                    3: v = 32'hFF80_0000;   // -inf
                    4: v = 32'h7FC0_0000;   // quiet nan
                    5: v = 32'hFFFF_FFFF;   // largest negative nan
                    6: v = 32'h7FFF_FFFF;   // largest positive nan
                    7: v = 32'h0000_0001;   // smallest denormal
                    default: v = 32'h8000_0001;
                endcase
            end
            1: v = prev;                                        // tie
            2: v = prev ^ (32'd1 << $urandom_range(0, 22));     // close neighbor
            3: v = {1'($urandom_range(0, 1)), 8'($urandom_range(120, 134)),
                    23'($urandom())};                           // logit-like range
            default: v = $urandom();
        endcase
        return v;
    endfunction

    // result side: check each transfer, idle in bursts, one long hold-off
    initial begin : result_side
        t_ranked_elem want;
        t_ranked_elem got;
        int           stall_left;
        stall_left = 0;
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            @(posedge i_clk);
            if (o_m_tvalid && m_tready) begin
                got.pos       = o_m_tdata[POSITION_W-1:0];
                got.score     = o_m_tdata[POSITION_W +: VALUE_W];
                got.final_res = o_m_tlast;
                got.overflow  = o_m_tuser[0];
                if (pending_ranks.size() == 0) begin
                    mismatches++;
                    $display("%0t: unexpected result pos=%0d score=%h final=%b ovf=%b",
                             $time, got.pos, got.score, got.final_res, got.overflow);
                end else begin
                    want = pending_ranks.pop_front();
                    if (got !== want) begin
                        mismatches++;
                        // pos/score/final/ovf
                        $display("%0t: mismatch expected %0d/%h/%b/%b actual %0d/%h/%b/%b",
                                 $time, want.pos, want.score, want.final_res, want.overflow,
                                 got.pos, got.score, got.final_res, got.overflow);
                    end
                end
            end
            if (stall_left != 0) begin
                stall_left--;
                m_tready <= 1'b0;
            end else if (!hold_done && s_tvalid && s_tlast && o_m_tvalid) begin
                // long hold-off while a run end is offered: the block stalls its input
                hold_done  = 1'b1;
                stall_left = HOLD_CYCLES - 1;
                m_tready  <= 1'b0;
            end else if (idle_on && !quiet && $urandom_range(0, 4) == 0) begin
                stall_left = $urandom_range(1, 5) - 1;
                m_tready  <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // input side and sequencing
    initial begin : input_side
        t_stim_row          row;
        t_ranked_elem       typed_res;
        logic [VALUE_W-1:0] prev;
        int                 random_sent;
        int                 run_len;
        int                 split_at;
        int                 k_pick;

        // directed table; typed rows run with k = 1 so one result is read off directly
        // reset value of top_count
        add_row(ROW_ITEM, 32'h3F80_0000, 1'b1, 1, 18'd0, 32'h3F80_0000);
        // -nan below -0 below +0
        add_row(ROW_ITEM, 32'hFFFF_FFFF, 1'b0, 0, '0, '0);
        add_row(ROW_ITEM, 32'h0000_0000, 1'b0, 0, '0, '0);
        add_row(ROW_ITEM, 32'h8000_0000, 1'b1, 1, 18'd1, 32'h0000_0000);
        // tie goes to the earlier position
        add_row(ROW_ITEM, 32'h4000_0000, 1'b0, 0, '0, '0);
        add_row(ROW_ITEM, 32'h4000_0000, 1'b1, 1, 18'd0, 32'h4000_0000);
        // top_count of zero acts as one; +nan above +inf
        add_row(ROW_CFG,  32'd0,         1'b0, 0, '0, '0);
        add_row(ROW_ITEM, 32'h7F80_0000, 1'b0, 0, '0, '0);
        add_row(ROW_ITEM, 32'h7FFF_FFFF, 1'b1, 1, 18'd1, 32'h7FFF_FFFF);
        // top_count above the list depth, short run gives fewer results
        add_row(ROW_CFG,  32'd31,        1'b0, 0, '0, '0);
        add_row(ROW_ITEM, 32'hFF80_0000, 1'b0, 0, '0, '0);
        add_row(ROW_ITEM, 32'h8000_0001, 1'b0, 0, '0, '0);
        add_row(ROW_ITEM, 32'h0000_0001, 1'b0, 0, '0, '0);
        add_row(ROW_ITEM, 32'h7F7F_FFFF, 1'b1, 0, '0, '0);
        // k changed in the middle of a run
        add_row(ROW_CFG,  32'd2,         1'b0, 0, '0, '0);
        add_row(ROW_ITEM, 32'h0000_0005, 1'b0, 0, '0, '0);
        add_row(ROW_ITEM, 32'hC000_0000, 1'b0, 0, '0, '0);
        add_row(ROW_CFG,  32'd3,         1'b0, 0, '0, '0);
        add_row(ROW_ITEM, 32'h3F00_0000, 1'b1, 0, '0, '0);
        // full depth with negative ties
        add_row(ROW_CFG,  32'd16,        1'b0, 0, '0, '0);
        add_row(ROW_ITEM, 32'hBF80_0000, 1'b0, 0, '0, '0);
        add_row(ROW_ITEM, 32'h3F80_0000, 1'b0, 0, '0, '0);
        add_row(ROW_ITEM, 32'hBF80_0000, 1'b1, 0, '0, '0);

        // hold synchronous reset, then release it
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (stim_rows[i]) begin
            row = stim_rows[i];
            if (row.kind == ROW_CFG) begin
                release_input();
                wait_idle();
                write_top_count(row.value[TOP_COUNT_W-1:0]);
            end else begin
                push_element(row.value, row.last, !row.typed);
                if (row.typed) begin
                    typed_res.pos       = row.t_pos;
                    typed_res.score     = row.t_score;
                    typed_res.final_res = 1'b1;
                    typed_res.overflow  = 1'b0;
                    pending_ranks.insert(pending_ranks.size(), typed_res);
                end
            end
        end

        // random phases: one k setting each, a few runs, now and then a k change mid-run
        prev        = 32'h3F80_0000;
        random_sent = 0;
        while (random_sent < RANDOM_ITEMS) begin
            release_input();
            wait_idle();
            case ($urandom_range(0, 9))
                0, 1:    k_pick = 1;
                2, 3:    k_pick = 16;
                4:       k_pick = 0;
                5:       k_pick = 31;
                default: k_pick = $urandom_range(2, 20);
            endcase
            write_top_count(k_pick[TOP_COUNT_W-1:0]);
            idle_on = ($urandom_range(0, 9) < 7);
            repeat ($urandom_range(2, 5)) begin
                run_len  = ($urandom_range(0, 4) == 0) ? $urandom_range(14, 24)
                                                       : $urandom_range(1, 10);
                split_at = (run_len > 1 && $urandom_range(0, 5) == 0)
                           ? $urandom_range(1, run_len - 1) : 0;
                for (int n = 0; n < run_len; n++) begin
                    if (split_at != 0 && n == split_at) begin
                        release_input();
                        wait_idle();
                        write_top_count(5'($urandom_range(0, 31)));
                    end
                    prev = pick_value(prev);
                    push_element(prev, n == run_len - 1, 1'b1);
                    random_sent++;
                end
            end
        end

        // closing part without idling: a full run, then a single element whose
        // run end meets the results still draining, then one more run of random length
        release_input();
        wait_idle();
        write_top_count(5'd17);
        quiet = 1'b1;
        for (int r = 0; r < 3; r++) begin
            run_len = (r == 0) ? 20 : ((r == 1) ? 1 : $urandom_range(1, 20));
            for (int n = 0; n < run_len; n++) begin
                prev = pick_value(prev);
                push_element(prev, n == run_len - 1, 1'b1);
            end
        end
        release_input();

        // drain, then allow for anything trailing
        while (pending_ranks.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
